@@ sv/cls_pkg.sv @@
// Shared widths, operation and status codes, and controller/datapath interface types.
`timescale 1ns / 1ps
package cls_pkg;

  localparam int OP_W  = 2;
  localparam int VAL_W = 16;
  localparam int POS_W = 8;
  localparam int ST_W  = 2;
  localparam int CNT_W = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic            capture;
    logic            idx_inc;
    logic            rd_idx;
    logic            rd_next;
    logic            rd_rem;
    logic            wr_shift;
    logic            insert;
    logic            count_dec;
    logic            mod_start;
    logic            res_set;
    logic [ST_W-1:0] res_status;
    logic            res_take_rd;
    logic            out_load;
  } cls_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            match;
    logic            idx_last;
    logic            shift_last;
    logic            mod_done;
    logic            out_free;
  } cls_sts_t;

endpackage

@@ sv/cls_mod.sv @@
// Iterative restoring remainder unit: position modulo entry count, one bit per cycle.
`timescale 1ns / 1ps
module cls_mod #(
  parameter int CW = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [cls_pkg::POS_W-1:0] dividend_i,
  input  logic [CW-1:0]            divisor_i,
  output logic                     busy_o,
  output logic [CW-1:0]            rem_o
);
  import cls_pkg::*;

  localparam int BW = $clog2(POS_W);

  logic          busy_q, busy_d;
  logic [BW-1:0] bit_q, bit_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW:0]   trial;
  logic [CW:0]   diff;

  assign trial = {rem_q, dividend_i[bit_q]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    bit_d  = bit_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      bit_d  = BW'(POS_W - 1);
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, divisor_i}) ? diff[CW-1:0] : trial[CW-1:0];
      bit_d = bit_q - 1'b1;
      if (bit_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      busy_q <= busy_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

@@ sv/cls_dp.sv @@
// Datapath: ring memory with head pointer, count, walk index, remainder unit, result registers.
`timescale 1ns / 1ps
module cls_dp #(
  parameter int DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [cls_pkg::OP_W-1:0]  operation_i,
  input  logic [cls_pkg::VAL_W-1:0] item_value_i,
  input  logic [cls_pkg::POS_W-1:0] position_i,
  input  cls_pkg::cls_cmd_t         cmd_i,
  output cls_pkg::cls_sts_t         sts_o,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic [cls_pkg::ST_W-1:0]  status_o,
  output logic [cls_pkg::VAL_W-1:0] read_value_o,
  output logic [cls_pkg::CNT_W-1:0] entry_count_o
);
  import cls_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(k);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  logic [VAL_W-1:0] mem_q [DEPTH];
  logic [VAL_W-1:0] rdata_q;

  logic [OP_W-1:0]  op_q;
  logic [VAL_W-1:0] val_q;
  logic [POS_W-1:0] pos_q;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [ST_W-1:0]  res_status_q;
  logic [VAL_W-1:0] res_val_q;
  logic             out_valid_q, out_valid_d;
  logic [ST_W-1:0]  out_status_q;
  logic [VAL_W-1:0] out_val_q;
  logic [CNT_W-1:0] out_cnt_q;

  logic [AW-1:0]    head_dec;
  logic [CW-1:0]    idx_p1;
  logic [CW-1:0]    count_m1;
  logic [CW-1:0]    rem;
  logic [CW-1:0]    rd_k;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic             we;
  logic             re;
  logic             mod_busy;
  logic [CW+CNT_W-1:0] count_ext;

  cls_mod #(.CW(CW)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (pos_q),
    .divisor_i  (count_q),
    .busy_o     (mod_busy),
    .rem_o      (rem)
  );

  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
  assign idx_p1   = idx_q + 1'b1;
  assign count_m1 = count_q - 1'b1;

  assign rd_k  = cmd_i.rd_rem ? rem : (cmd_i.rd_next ? idx_p1 : idx_q);
  assign raddr = phys(head_q, rd_k);
  assign re    = cmd_i.rd_idx | cmd_i.rd_next | cmd_i.rd_rem;
  assign we    = cmd_i.insert | cmd_i.wr_shift;
  assign waddr = cmd_i.insert ? head_dec : phys(head_q, idx_q);
  assign wdata = cmd_i.insert ? val_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.capture) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_p1;
    end
    if (cmd_i.insert) begin
      head_d  = head_dec;
      count_d = count_q + 1'b1;
    end else if (cmd_i.count_dec) begin
      count_d = count_m1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign count_ext = (CW+CNT_W)'(count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= operation_i;
      val_q <= item_value_i;
      pos_q <= position_i;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_val_q    <= cmd_i.res_take_rd ? rdata_q : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_val_q    <= res_val_q;
      out_cnt_q    <= count_ext[CNT_W-1:0];
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.full       = (count_q == CW'(DEPTH));
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.match      = (rdata_q == val_q);
  assign sts_o.idx_last   = (idx_q == count_m1);
  assign sts_o.shift_last = (idx_p1 == count_m1);
  assign sts_o.mod_done   = !mod_busy;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_value_o  = out_val_q;
  assign entry_count_o = out_cnt_q;

endmodule

@@ sv/cls_ctrl.sv @@
// Controller: sequences insert, search-and-shift remove, and modulo read over the datapath.
`timescale 1ns / 1ps
module cls_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              busy_o,
  output cls_pkg::cls_cmd_t cmd_o,
  input  cls_pkg::cls_sts_t sts_i
);
  import cls_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECODE   = 8'b0000_0010,
    S_SRCH     = 8'b0000_0100,
    S_SHIFT_WR = 8'b0000_1000,
    S_SHIFT_RD = 8'b0001_0000,
    S_MOD      = 8'b0010_0000,
    S_RD_DATA  = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.op)
          OP_INSERT: begin
            cmd_o.res_set = 1'b1;
            if (sts_i.full) begin
              cmd_o.res_status = ST_FULL;
            end else begin
              cmd_o.insert     = 1'b1;
              cmd_o.res_status = ST_DONE;
            end
            state_d = S_DONE;
          end
          OP_REMOVE: begin
            if (sts_i.empty) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ST_EMPTY;
              state_d          = S_DONE;
            end else begin
              cmd_o.rd_idx = 1'b1;
              state_d      = S_SRCH;
            end
          end
          OP_READ: begin
            if (sts_i.empty) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ST_EMPTY;
              state_d          = S_DONE;
            end else begin
              cmd_o.mod_start = 1'b1;
              state_d         = S_MOD;
            end
          end
          default: begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_DONE;
            state_d          = S_DONE;
          end
        endcase
      end
      S_SRCH: begin
        if (sts_i.match) begin
          if (sts_i.idx_last) begin
            cmd_o.count_dec  = 1'b1;
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_DONE;
            state_d          = S_DONE;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = S_SHIFT_WR;
          end
        end else if (sts_i.idx_last) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_MISSING;
          state_d          = S_DONE;
        end else begin
          cmd_o.rd_next = 1'b1;
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        if (sts_i.shift_last) begin
          cmd_o.count_dec  = 1'b1;
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_DONE;
          state_d          = S_DONE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd_o.rd_next = 1'b1;
        state_d       = S_SHIFT_WR;
      end
      S_MOD: begin
        if (sts_i.mod_done) begin
          cmd_o.rd_rem = 1'b1;
          state_d      = S_RD_DATA;
        end
      end
      S_RD_DATA: begin
        cmd_o.res_set     = 1'b1;
        cmd_o.res_status  = ST_DONE;
        cmd_o.res_take_rd = 1'b1;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

@@ sv/circular_list_store_top.sv @@
// Top level: ordered ring of identifiers with insert-at-front, remove-first-match, wrapped read.
// Insert: the entry is written at the new head during decode, then the result is loaded.
// Remove: the search walks from the front to the first match at index k, then the n entries
// behind it are shifted forward; a miss walks the whole count; an empty ring answers at decode.
// Read: waits on the 8-step bit-serial remainder unit, then one memory read.
// One request in flight; a new one is taken while the previous result still waits.
// Reset clears the count, head pointer and controller; ring storage holds no reset value.
`timescale 1ns / 1ps
module circular_list_store_top #(
  parameter int DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [cls_pkg::OP_W-1:0]  operation_i,
  input  logic [cls_pkg::VAL_W-1:0] item_value_i,
  input  logic [cls_pkg::POS_W-1:0] position_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [cls_pkg::ST_W-1:0]  status_o,
  output logic [cls_pkg::VAL_W-1:0] read_value_o,
  output logic [cls_pkg::CNT_W-1:0] entry_count_o
);
  import cls_pkg::*;

  cls_cmd_t cmd;
  cls_sts_t sts;
  logic     busy;

  cls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .busy_o     (busy),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  cls_dp #(.DEPTH(DEPTH)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .operation_i   (operation_i),
    .item_value_i  (item_value_i),
    .position_i    (position_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o)
  );

  assign in_stall_o = busy;

endmodule

@@ sv/cls_chk.sv @@
// Port-level checker for the ring store, bound to the top level.
`timescale 1ns / 1ps
module cls_chk #(
  parameter int DEPTH = 64
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic [cls_pkg::OP_W-1:0]  operation_i,
  input logic [cls_pkg::VAL_W-1:0] item_value_i,
  input logic [cls_pkg::POS_W-1:0] position_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [cls_pkg::ST_W-1:0]  status_o,
  input logic [cls_pkg::VAL_W-1:0] read_value_o,
  input logic [cls_pkg::CNT_W-1:0] entry_count_o
);
  import cls_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(read_value_o) && $stable(entry_count_o))
    else $error("stalled result changed");

  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> entry_count_o == FULL_CNT)
    else $error("full refusal with count below depth");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> entry_count_o == '0 && read_value_o == '0)
    else $error("empty status with nonzero count or value");

  a_val_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_value_o != '0 |-> status_o == ST_DONE)
    else $error("read value on a failed request");

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (DEPTH > 127) || (int'(entry_count_o) <= DEPTH))
    else $error("count above depth");

endmodule

bind circular_list_store_top cls_chk #(.DEPTH(DEPTH)) u_cls_chk (.*);
